>>> design/tlc_pkg.sv
// shared types, constants and helpers of the two-way traffic light controller
// no dependencies; imported by tlc_next, the top level and its checker

package tlc_pkg;

   localparam int unsigned TICK_W    = 7;
   localparam int unsigned BCD_W     = 8;
   localparam int unsigned DIGIT_N   = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0] TICKS_MIN = 7'd1;
   localparam logic [TICK_W-1:0] TICKS_MAX = 7'd99;

   localparam logic [TICK_W-1:0] LONG_GREEN_RESET  = 7'd20;
   localparam logic [TICK_W-1:0] SHORT_GREEN_RESET = 7'd12;
   localparam logic [TICK_W-1:0] YELLOW_RESET      = 7'd3;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_GREEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW      = 2'd2;

   // digit enable patterns
   localparam logic [DIGIT_N-1:0] DIGITS_OFF        = 4'h0;
   localparam logic [DIGIT_N-1:0] DIGITS_ALL        = 4'hF;
   localparam logic [DIGIT_N-1:0] DIGITS_STREET_ONE = 4'hC;
   localparam logic [DIGIT_N-1:0] DIGITS_STREET_TWO = 4'h3;

   localparam logic STREET_ONE = 1'b0;
   localparam logic STREET_TWO = 1'b1;

   typedef enum logic [1:0] {
      LAMP_RED    = 2'd0,
      LAMP_YELLOW = 2'd1,
      LAMP_GREEN  = 2'd2
   } lamp_type;

   typedef enum logic [1:0] {
      PH_FAV_GREEN   = 2'd0,
      PH_FAV_YELLOW  = 2'd1,
      PH_OTH_GREEN   = 2'd2,
      PH_OTH_YELLOW  = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [TICK_W-1:0] remaining;
      logic              favoured;
      logic              manual;
      logic              pending;
   } ctl_state_type;

   typedef struct packed {
      logic [TICK_W-1:0] long_green;
      logic [TICK_W-1:0] short_green;
      logic [TICK_W-1:0] yellow;
   } timing_type;

   typedef struct packed {
      lamp_type           street_one;
      lamp_type           street_two;
      logic [BCD_W-1:0]   countdown;
      logic [DIGIT_N-1:0] enables;
   } result_type;

   function automatic logic [TICK_W-1:0] clamp_ticks(input logic [TICK_W-1:0] v);
      logic [TICK_W-1:0] r;
      if (v < TICKS_MIN) begin
         r = TICKS_MIN;
      end else if (v > TICKS_MAX) begin
         r = TICKS_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // tens digit by reciprocal multiply, exact below 100
   function automatic logic [BCD_W-1:0] to_bcd(input logic [TICK_W-1:0] v);
      logic [TICK_W-1:0] c;
      logic [13:0]       prod;
      logic [3:0]        tens;
      logic [TICK_W-1:0] ones;
      c    = (v > TICKS_MAX) ? TICKS_MAX : v;
      prod = 14'(c) * 14'd103;
      tens = prod[13:10];
      ones = c - TICK_W'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

>>> design/tlc_next.sv
// next-state and display logic for one tick of the traffic light controller
// depends on tlc_pkg

module tlc_next (
   input  tlc_pkg::ctl_state_type cur,
   input  tlc_pkg::timing_type    timing,
   input  logic                   hold,
   input  logic                   button,
   output tlc_pkg::ctl_state_type nxt,
   output tlc_pkg::result_type    res
);
   import tlc_pkg::*;

   lamp_type          fav_lamp;
   lamp_type          oth_lamp;
   lamp_type          one_lamp;
   lamp_type          two_lamp;
   logic              pend;
   logic              start;
   logic [TICK_W-1:0] next_len;
   phase_type         next_phase;

   // lamps of the automatic phase relative to the favoured street
   always_comb begin
      case (cur.phase)
         PH_FAV_GREEN: begin
            fav_lamp = LAMP_GREEN;
            oth_lamp = LAMP_RED;
         end
         PH_FAV_YELLOW: begin
            fav_lamp = LAMP_YELLOW;
            oth_lamp = LAMP_RED;
         end
         PH_OTH_GREEN: begin
            fav_lamp = LAMP_RED;
            oth_lamp = LAMP_GREEN;
         end
         default: begin
            fav_lamp = LAMP_RED;
            oth_lamp = LAMP_YELLOW;
         end
      endcase
      one_lamp = (cur.favoured == STREET_ONE) ? fav_lamp : oth_lamp;
      two_lamp = (cur.favoured == STREET_ONE) ? oth_lamp : fav_lamp;
   end

   assign pend       = cur.pending | button;
   assign start      = !cur.manual && hold && pend;
   assign next_phase = phase_type'(cur.phase + 2'd1);

   always_comb begin
      case (next_phase)
         PH_FAV_GREEN: next_len = clamp_ticks(timing.long_green);
         PH_OTH_GREEN: next_len = clamp_ticks(timing.short_green);
         default:      next_len = clamp_ticks(timing.yellow);
      endcase
   end

   always_comb begin
      logic              fav;
      logic [TICK_W-1:0] rem;
      fav         = cur.favoured;
      rem         = cur.remaining;
      nxt         = cur;
      nxt.pending = pend;
      res.street_one = one_lamp;
      res.street_two = two_lamp;
      res.countdown  = '0;
      res.enables    = DIGITS_OFF;

      // a served press swaps right of way: the red street becomes favoured
      if (start) begin
         fav         = (one_lamp == LAMP_RED) ? STREET_ONE : STREET_TWO;
         rem         = clamp_ticks(timing.yellow);
         nxt.pending = 1'b0;
      end

      if (cur.manual || start) begin
         res.street_one = (fav == STREET_ONE) ? LAMP_RED : LAMP_YELLOW;
         res.street_two = (fav == STREET_ONE) ? LAMP_YELLOW : LAMP_RED;
         res.countdown  = to_bcd(rem);
         res.enables    = (fav == STREET_ONE) ? DIGITS_STREET_ONE : DIGITS_STREET_TWO;
         nxt.favoured   = fav;
         if (rem <= TICKS_MIN) begin
            nxt.manual    = 1'b0;
            nxt.phase     = PH_FAV_GREEN;
            nxt.remaining = clamp_ticks(timing.long_green);
         end else begin
            nxt.manual    = 1'b1;
            nxt.remaining = rem - 7'd1;
         end
      end else if (!hold) begin
         res.countdown = to_bcd(rem);
         res.enables   = DIGITS_ALL;
         if (rem <= TICKS_MIN) begin
            nxt.phase     = next_phase;
            nxt.remaining = next_len;
         end else begin
            nxt.remaining = rem - 7'd1;
         end
      end
   end

endmodule

>>> design/two_way_traffic_light_controller_unit.sv
// Two-way traffic light controller. Each req beat is one display tick with the
// hold switch and a button event; each tick yields exactly one rsp beat with
// both street lamps, the BCD countdown and the digit enables. The controller
// state updates at the accepting edge and the result lands in the output
// register, so one tick per cycle is sustained while rsp_ready stays high,
// and a tick is accepted whenever the output register is empty or being
// drained in the same cycle. Timing registers (long green, short green,
// yellow, in ticks) are written through the csr port; 0 acts as 1 and
// values above 99 act as 99.
// depends on tlc_pkg and tlc_next

module two_way_traffic_light_controller_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_hold_switch,
   input  logic                            req_button_press,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_street_one_lamp,
   output logic [1:0]                      rsp_street_two_lamp,
   output logic [tlc_pkg::BCD_W-1:0]       rsp_countdown_bcd,
   output logic [tlc_pkg::DIGIT_N-1:0]     rsp_digit_enables,
   input  logic                            csr_write_enable,
   input  logic [tlc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tlc_pkg::TICK_W-1:0]      csr_data
);
   import tlc_pkg::*;

   timing_type    timing_ff;
   ctl_state_type state_ff;
   ctl_state_type state_in;
   result_type    result_ff;
   result_type    result_in;
   logic          rsp_valid_ff;
   logic          accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   tlc_next u_next (
      .cur    (state_ff),
      .timing (timing_ff),
      .hold   (req_hold_switch),
      .button (req_button_press),
      .nxt    (state_in),
      .res    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.long_green  <= LONG_GREEN_RESET;
         timing_ff.short_green <= SHORT_GREEN_RESET;
         timing_ff.yellow      <= YELLOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LONG_GREEN:  timing_ff.long_green  <= csr_data;
            CSR_SHORT_GREEN: timing_ff.short_green <= csr_data;
            CSR_YELLOW:      timing_ff.yellow      <= csr_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_FAV_GREEN;
         state_ff.remaining <= LONG_GREEN_RESET;
         state_ff.favoured  <= STREET_TWO;
         state_ff.manual    <= 1'b0;
         state_ff.pending   <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_street_one_lamp = result_ff.street_one;
   assign rsp_street_two_lamp = result_ff.street_two;
   assign rsp_countdown_bcd   = result_ff.countdown;
   assign rsp_digit_enables   = result_ff.enables;

endmodule

>>> design/tlc_checker.sv
// port-level checks for the traffic light controller, bound to the top level
// depends on tlc_pkg and two_way_traffic_light_controller_unit

module tlc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_street_one_lamp,
   input logic [1:0]                    rsp_street_two_lamp,
   input logic [tlc_pkg::BCD_W-1:0]     rsp_countdown_bcd,
   input logic [tlc_pkg::DIGIT_N-1:0]   rsp_digit_enables
);
   import tlc_pkg::*;

   // never green or yellow on both streets at once
   a_one_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_street_one_lamp == LAMP_RED || rsp_street_two_lamp == LAMP_RED))
      else $error("both streets show a non-red lamp");

   // dark digits carry a zero count, lit digits a nonzero valid bcd count
   a_dark_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_enables == DIGITS_OFF) |-> rsp_countdown_bcd == '0)
      else $error("count shown while digits are dark");

   a_lit_bcd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_enables != DIGITS_OFF) |->
         (rsp_countdown_bcd != '0 && rsp_countdown_bcd[3:0] <= 4'd9
          && rsp_countdown_bcd[7:4] <= 4'd9))
      else $error("bad countdown on lit digits");

   // a manual countdown lit on street one's digits shows yellow on street two, whose digits are dark
   a_manual_lamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_enables == DIGITS_STREET_ONE) |->
         (rsp_street_one_lamp == LAMP_RED && rsp_street_two_lamp == LAMP_YELLOW))
      else $error("manual change lamps wrong");

   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_countdown_bcd)))
      else $error("stalled rsp beat changed");

endmodule

bind two_way_traffic_light_controller_unit tlc_checker u_tlc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_street_one_lamp (rsp_street_one_lamp),
   .rsp_street_two_lamp (rsp_street_two_lamp),
   .rsp_countdown_bcd   (rsp_countdown_bcd),
   .rsp_digit_enables   (rsp_digit_enables)
);

>>> sim/tb_two_way_traffic_light_controller_unit.sv
// self-checking testbench of the two-way traffic light controller: display ticks
// and timing register writes in, every lamp/countdown beat predicted and compared
// depends on tlc_pkg and two_way_traffic_light_controller_unit

module tb_two_way_traffic_light_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tlc_pkg::*;

   localparam int unsigned IDLE_PCT        = 18;
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT     = 300000;

   // index 3 is not a register, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic hold;
      logic press;
   } tick_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_hold_switch  = 1'b0;
   logic                 req_button_press = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [1:0]           rsp_street_one_lamp;
   logic [1:0]           rsp_street_two_lamp;
   logic [BCD_W-1:0]     rsp_countdown_bcd;
   logic [DIGIT_N-1:0]   rsp_digit_enables;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [TICK_W-1:0]    csr_data         = '0;

   // timing copy and controller state as the predictor sees them
   logic [TICK_W-1:0] long_cfg      = LONG_GREEN_RESET;
   logic [TICK_W-1:0] short_cfg     = SHORT_GREEN_RESET;
   logic [TICK_W-1:0] yellow_cfg    = YELLOW_RESET;
   phase_type         cur_phase     = PH_FAV_GREEN;
   logic [TICK_W-1:0] ticks_left    = LONG_GREEN_RESET;
   logic              cur_fav       = STREET_TWO;
   logic              in_manual     = 1'b0;
   logic              press_waiting = 1'b0;

   tick_type    ticks_pending[$];
   result_type  lights_due[$];
   int unsigned ticks_made     = 0;
   int unsigned ticks_sent     = 0;
   int unsigned mismatches     = 0;
   int unsigned cycles         = 0;
   int unsigned hold_off_asked = 0;
   int unsigned hold_off_seen  = 0;
   int unsigned stall_left     = 0;
   logic        calm           = 1'b0;
   logic        tick_taken     = 1'b0;

   two_way_traffic_light_controller_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_hold_switch     (req_hold_switch),
      .req_button_press    (req_button_press),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_street_one_lamp (rsp_street_one_lamp),
      .rsp_street_two_lamp (rsp_street_two_lamp),
      .rsp_countdown_bcd   (rsp_countdown_bcd),
      .rsp_digit_enables   (rsp_digit_enables),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [TICK_W-1:0] ticks_used(input logic [TICK_W-1:0] v);
      logic [TICK_W-1:0] r;
      r = v;
      if (v < TICKS_MIN) begin
         r = TICKS_MIN;
      end else if (v > TICKS_MAX) begin
         r = TICKS_MAX;
      end
      return r;
   endfunction

   function automatic logic [BCD_W-1:0] bcd_of(input logic [TICK_W-1:0] v);
      logic [TICK_W-1:0] c;
      c = (v > TICKS_MAX) ? TICKS_MAX : v;
      return {4'(c / 10), 4'(c % 10)};
   endfunction

   function automatic logic [TICK_W-1:0] span_of(input phase_type p);
      logic [TICK_W-1:0] r;
      case (p)
         PH_FAV_GREEN: r = ticks_used(long_cfg);
         PH_OTH_GREEN: r = ticks_used(short_cfg);
         default:      r = ticks_used(yellow_cfg);
      endcase
      return r;
   endfunction

   function automatic void show_phase(output lamp_type one, output lamp_type two);
      lamp_type fav_lamp;
      lamp_type oth_lamp;
      case (cur_phase)
         PH_FAV_GREEN: begin
            fav_lamp = LAMP_GREEN;
            oth_lamp = LAMP_RED;
         end
         PH_FAV_YELLOW: begin
            fav_lamp = LAMP_YELLOW;
            oth_lamp = LAMP_RED;
         end
         PH_OTH_GREEN: begin
            fav_lamp = LAMP_RED;
            oth_lamp = LAMP_GREEN;
         end
         default: begin
            fav_lamp = LAMP_RED;
            oth_lamp = LAMP_YELLOW;
         end
      endcase
      if (cur_fav == STREET_ONE) begin
         one = fav_lamp;
         two = oth_lamp;
      end else begin
         one = oth_lamp;
         two = fav_lamp;
      end
   endfunction

   // one display tick: updates the predicted controller state, returns the beat
   function automatic result_type step_signal(input logic hold, input logic press);
      result_type r;
      lamp_type   one;
      lamp_type   two;
      r.countdown = '0;
      r.enables   = DIGITS_OFF;
      if (press) begin
         press_waiting = 1'b1;
      end
      if (!in_manual && hold && press_waiting) begin
         show_phase(one, two);
         press_waiting = 1'b0;
         // the street that was red takes right of way
         cur_fav    = (one == LAMP_RED) ? STREET_ONE : STREET_TWO;
         in_manual  = 1'b1;
         ticks_left = ticks_used(yellow_cfg);
      end
      if (in_manual) begin
         if (cur_fav == STREET_ONE) begin
            one       = LAMP_RED;
            two       = LAMP_YELLOW;
            r.enables = DIGITS_STREET_ONE;
         end else begin
            one       = LAMP_YELLOW;
            two       = LAMP_RED;
            r.enables = DIGITS_STREET_TWO;
         end
         r.countdown = bcd_of(ticks_left);
         if (ticks_left <= TICKS_MIN) begin
            in_manual  = 1'b0;
            cur_phase  = PH_FAV_GREEN;
            ticks_left = span_of(PH_FAV_GREEN);
         end else begin
            ticks_left = ticks_left - 7'd1;
         end
      end else begin
         show_phase(one, two);
         if (!hold) begin
            r.countdown = bcd_of(ticks_left);
            r.enables   = DIGITS_ALL;
            if (ticks_left <= TICKS_MIN) begin
               cur_phase  = phase_type'(cur_phase + 2'd1);
               ticks_left = span_of(cur_phase);
            end else begin
               ticks_left = ticks_left - 7'd1;
            end
         end
      end
      r.street_one = one;
      r.street_two = two;
      return r;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      case (idx)
         CSR_LONG_GREEN:  long_cfg = data;
         CSR_SHORT_GREEN: short_cfg = data;
         CSR_YELLOW:      yellow_cfg = data;
         default:         ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_tick(input logic hold, input logic press);
      tick_type t;
      t.hold  = hold;
      t.press = press;
      ticks_pending.push_back(t);
      ticks_made++;
   endtask

   task automatic offer(input int unsigned n, input int unsigned hold_pct,
                        input int unsigned press_pct);
      @(posedge clock);
      repeat (n) begin
         queue_tick($urandom_range(99) < hold_pct, $urandom_range(99) < press_pct);
      end
   endtask

   // back to idle: every tick taken and every beat seen
   task automatic drain();
      while (ticks_sent != ticks_made || lights_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin : driver
      tick_type t;
      if (!req_valid || tick_taken) begin
         if (ticks_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            t = ticks_pending.pop_front();
            req_valid        <= 1'b1;
            req_hold_switch  <= t.hold;
            req_button_press <= t.press;
         end else begin
            req_valid        <= 1'b0;
            req_hold_switch  <= 1'($urandom);
            req_button_press <= 1'($urandom);
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (hold_off_seen != hold_off_asked) begin
         hold_off_seen = hold_off_asked;
         stall_left    = HOLD_OFF_CYCLES;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      tick_taken = req_valid && req_ready;
      if (!reset) begin
         if (tick_taken) begin
            lights_due.push_back(step_signal(req_hold_switch, req_button_press));
            ticks_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (lights_due.size() == 0) begin
               $error("result beat with no tick waiting for it");
               mismatches++;
            end else begin
               want = lights_due.pop_front();
               if (rsp_street_one_lamp !== want.street_one) begin
                  $error("street_one_lamp: expected %0d, got %0d",
                         want.street_one, rsp_street_one_lamp);
                  mismatches++;
               end
               if (rsp_street_two_lamp !== want.street_two) begin
                  $error("street_two_lamp: expected %0d, got %0d",
                         want.street_two, rsp_street_two_lamp);
                  mismatches++;
               end
               if (rsp_countdown_bcd !== want.countdown) begin
                  $error("countdown_bcd: expected %h, got %h",
                         want.countdown, rsp_countdown_bcd);
                  mismatches++;
               end
               if (rsp_digit_enables !== want.enables) begin
                  $error("digit_enables: expected %h, got %h",
                         want.enables, rsp_digit_enables);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_two_way_traffic_light_controller_unit NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      logic [TICK_W-1:0] lg;
      logic [TICK_W-1:0] sg;
      logic [TICK_W-1:0] yl;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timing; plain ticks, then a press outside hold that waits for hold
      @(posedge clock);
      queue_tick(1'b0, 1'b0);
      queue_tick(1'b0, 1'b1);
      queue_tick(1'b0, 1'b0);
      // hold serves the waiting press; presses during the countdown stay pending
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b0, 1'b1);
      queue_tick(1'b1, 1'b1);
      queue_tick(1'b0, 1'b0);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b0, 1'b0);
      // hold alone freezes the lamps and blanks the digits
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b0, 1'b0);
      // press inside hold is served on the same tick
      queue_tick(1'b1, 1'b1);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b0, 1'b0);
      queue_tick(1'b0, 1'b1);
      queue_tick(1'b1, 1'b0);
      queue_tick(1'b0, 1'b0);
      queue_tick(1'b0, 1'b0);
      drain();

      // one-tick phases, no idling, and one long receiver hold-off
      write_reg(CSR_LONG_GREEN, TICKS_MIN);
      write_reg(CSR_SHORT_GREEN, TICKS_MIN);
      write_reg(CSR_YELLOW, TICKS_MIN);
      @(posedge clock);
      calm = 1'b1;
      offer(200, 20, 10);
      hold_off_asked++;
      drain();
      @(posedge clock);
      calm = 1'b0;

      // out of range values are clamped; the spare index is ignored
      write_reg(CSR_LONG_GREEN, 7'd0);
      write_reg(CSR_SHORT_GREEN, 7'd100);
      write_reg(CSR_YELLOW, 7'd127);
      write_reg(CSR_SPARE, 7'd5);
      offer(200, 25, 15);
      drain();

      write_reg(CSR_LONG_GREEN, TICKS_MAX);
      write_reg(CSR_SHORT_GREEN, TICKS_MAX);
      write_reg(CSR_YELLOW, TICKS_MAX);
      offer(200, 15, 5);
      drain();

      // mostly short timings so phases and manual changes keep coming
      repeat (4) begin
         lg = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 9));
         sg = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 9));
         yl = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 6));
         write_reg(CSR_LONG_GREEN, lg);
         write_reg(CSR_SHORT_GREEN, sg);
         write_reg(CSR_YELLOW, yl);
         if ($urandom_range(1) == 0) begin
            write_reg(CSR_SPARE, 7'($urandom_range(127)));
         end
         offer(200, $urandom_range(10, 40), $urandom_range(5, 25));
         drain();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && lights_due.size() == 0) begin
         $display("tb_two_way_traffic_light_controller_unit OK");
      end else begin
         $display("tb_two_way_traffic_light_controller_unit NOT OK");
      end
      $finish;
   end

endmodule
